[rtl/htr_pkg.sv]
// ============================================================================
// htr_pkg: shared types and constants of the triangle rasterizer
// Beat layouts, command and status codes, sequencer states and the control
// bundles that drive the shared multiplier and the divider.
// ============================================================================
`default_nettype none

package htr_pkg;

	// Command codes
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_TRI   = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Status codes
	localparam logic [1:0] STATUS_DONE   = 2'd0;
	localparam logic [1:0] STATUS_CULLED = 2'd1;
	localparam logic [1:0] STATUS_READ   = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_RED   = 2'd0;
	localparam logic [1:0] REG_GREEN = 2'd1;
	localparam logic [1:0] REG_BLUE  = 2'd2;
	localparam logic [1:0] REG_ALPHA = 2'd3;

	// Datapath widths
	localparam int ACC_W   = 98;
	localparam int CR_W    = 65;
	localparam int DEN_W   = 96;
	localparam int NUM_W   = 112;
	localparam int COEF_W  = 48;
	localparam int EDGE_W  = 64;
	localparam int DEPTH_W = 48;
	localparam int CNT_W   = 13;

	localparam logic [COEF_W-2:0] COEF_MAX  = '1;
	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [6:0]        DIV_LAST  = 7'(NUM_W - 1);

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] vert0_x;
		logic signed [31:0] vert0_y;
		logic signed [31:0] vert0_w;
		logic signed [31:0] vert1_x;
		logic signed [31:0] vert1_y;
		logic signed [31:0] vert1_w;
		logic signed [31:0] vert2_x;
		logic signed [31:0] vert2_y;
		logic signed [31:0] vert2_w;
		logic [1:0]         clear_mask;
		logic [11:0]        pixel_index;
	} in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [31:0]      pixel_color;
		logic [CNT_W-1:0] pixels_written;
	} out_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_READ,
		S_XMUL,
		S_XACC,
		S_XSTO,
		S_DMUL,
		S_DACC,
		S_DCHK,
		S_DIVGO,
		S_DIVW,
		S_PINIT,
		S_PIX,
		S_PDRAIN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic        issue;
		logic        clr;
		logic        neg;
		logic        sh;
		logic [31:0] a;
		logic [31:0] b;
	} mac_ctl_t;

	typedef struct packed {
		logic        start;
		logic        neg;
		logic [63:0] mag;
	} div_ctl_t;

	// Next index modulo three
	function automatic logic [1:0] inc3(input logic [1:0] v);
		return (v == 2'd2) ? 2'd0 : 2'(v + 2'd1);
	endfunction

	// Magnitude of a 32-bit signed value
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

endpackage

`default_nettype wire

[rtl/homogeneous_triangle_rasterizer_top.sv]
// A clear sweeps all SCREEN_WIDTH*SCREEN_HEIGHT pixels; a drawn triangle runs its setup,
// in which each of the nine coefficients holds the divider, and then walks the screen
// at one pixel per cycle.
// One item at a time; the next beat is taken once the result is registered.
// After reset both stores are zeroed by a pass over all SCREEN_WIDTH*SCREEN_HEIGHT
// pixels, during which no item is accepted.
// ============================================================================
// homogeneous_triangle_rasterizer_top: triangle rasterizer with frame stores
// Sequencer around a shared multiplier and divider, a one-pixel-per-cycle
// depth test pipeline, and colour and depth RAMs.
// ============================================================================
`default_nettype none

module homogeneous_triangle_rasterizer_top #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire htr_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output htr_pkg::out_t      out_data,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int PIX_CNT = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW      = (PIX_CNT > 1) ? $clog2(PIX_CNT) : 1;
	localparam int XW      = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam logic [AW-1:0] LAST_PIX = AW'(PIX_CNT - 1);
	localparam logic [XW-1:0] LAST_X   = XW'(SCREEN_WIDTH - 1);

	htr_pkg::state_t state_q, state_d;

	// Configuration
	logic [7:0] red_q, green_q, blue_q, alpha_q;

	// Item and setup storage
	logic signed [31:0]                  v_q   [3][3];
	logic signed [htr_pkg::CR_W-1:0]     cr_q  [3][3];
	logic signed [htr_pkg::COEF_W-1:0]   coef_q[3][3];
	logic [htr_pkg::DEN_W-1:0]           dmag_q;
	logic [1:0]                          k_q, j_q;
	logic                                term_q;
	logic [1:0]                          mask_q;
	logic                                inrange_q;

	// Result
	logic [1:0]                          res_status_q;
	logic [31:0]                         res_color_q;
	logic [htr_pkg::CNT_W-1:0]           count_q;
	logic                                out_valid_q;
	htr_pkg::out_t                       out_q;

	// Pixel walk and pipeline
	logic [AW-1:0]                       idx_q;
	logic [XW-1:0]                       x_q;
	logic signed [htr_pkg::EDGE_W-1:0]   e_q   [3];
	logic signed [htr_pkg::EDGE_W-1:0]   row_q [3];
	logic                                vld_s1;
	logic signed [htr_pkg::EDGE_W-1:0]   e_s1  [3];
	logic [AW-1:0]                       idx_s1;

	// Shared units
	htr_pkg::mac_ctl_t                   mac_c;
	htr_pkg::div_ctl_t                   div_c;
	logic signed [htr_pkg::ACC_W-1:0]    acc;
	logic                                div_done;
	logic signed [htr_pkg::COEF_W-1:0]   div_coef;

	// RAM ports
	logic                                we_c, we_d;
	logic [AW-1:0]                       waddr_c, waddr_d, raddr_c;
	logic [31:0]                         wdata_c, rdata_c;
	logic [htr_pkg::DEPTH_W-1:0]         wdata_d, rdata_d;

	// Pixel datapath
	logic                                cov, pass;
	logic [63:0]                         sum;
	logic [htr_pkg::COEF_W-2:0]          owsat;
	logic [htr_pkg::DEPTH_W-1:0]         new_depth;
	logic [31:0]                         new_color;
	logic                                in_acc, out_acc, cfg_wr;
	logic [1:0]                          ka, kb, p, q;
	logic [htr_pkg::CR_W-1:0]            crm;

	function automatic logic [7:0] chan(input logic signed [htr_pkg::EDGE_W-1:0] e);
		logic [40:0] t;
		t = {e[32:0], 8'd0} - {8'd0, e[32:0]};
		return (|e[62:33]) ? 8'hFF : t[40:33];
	endfunction

	function automatic logic signed [htr_pkg::EDGE_W-1:0] sx(
		input logic signed [htr_pkg::COEF_W-1:0] c);
		return {{(htr_pkg::EDGE_W - htr_pkg::COEF_W){c[htr_pkg::COEF_W-1]}}, c};
	endfunction

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign in_stall  = (state_q != htr_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Register read
	always_comb begin
		unique case (paddr[3:2])
			htr_pkg::REG_RED:   prdata = {24'd0, red_q};
			htr_pkg::REG_GREEN: prdata = {24'd0, green_q};
			htr_pkg::REG_BLUE:  prdata = {24'd0, blue_q};
			htr_pkg::REG_ALPHA: prdata = {24'd0, alpha_q};
		endcase
	end

	// Operand indexes for the cross products
	always_comb begin
		ka = htr_pkg::inc3(k_q);
		kb = htr_pkg::inc3(ka);
		p  = htr_pkg::inc3(j_q);
		q  = htr_pkg::inc3(p);
		crm = cr_q[0][j_q][htr_pkg::CR_W-1] ? htr_pkg::CR_W'(-cr_q[0][j_q])
		                                     : htr_pkg::CR_W'(cr_q[0][j_q]);
	end

	// Depth test and shading of the pixel in stage one
	always_comb begin
		cov = !e_s1[0][htr_pkg::EDGE_W-1] && !e_s1[1][htr_pkg::EDGE_W-1]
		   && !e_s1[2][htr_pkg::EDGE_W-1];
		sum = 64'(e_s1[0]) + 64'(e_s1[1]) + 64'(e_s1[2]);
		owsat = (|sum[63:48]) ? htr_pkg::COEF_MAX : sum[47:1];
		new_depth = {1'b0, owsat};
		pass = vld_s1 && cov && ($signed(new_depth) >= $signed(rdata_d));
		new_color = {chan(e_s1[0]), chan(e_s1[1]), chan(e_s1[2]), 8'hFF};
	end

	// Store write ports: sweeps or pixel writes
	always_comb begin
		raddr_c = AW'(in_data.pixel_index);
		priority if (state_q == htr_pkg::S_INIT) begin
			we_c = 1'b1;
			we_d = 1'b1;
			waddr_c = idx_q;
			waddr_d = idx_q;
			wdata_c = '0;
			wdata_d = '0;
		end else if (state_q == htr_pkg::S_CLEAR) begin
			we_c = mask_q[0];
			we_d = mask_q[1];
			waddr_c = idx_q;
			waddr_d = idx_q;
			wdata_c = {red_q, green_q, blue_q, alpha_q};
			wdata_d = '0;
		end else begin
			we_c = pass;
			we_d = pass;
			waddr_c = idx_s1;
			waddr_d = idx_s1;
			wdata_c = new_color;
			wdata_d = new_depth;
		end
	end

	// Next state and unit control
	always_comb begin
		state_d = state_q;
		mac_c   = '0;
		div_c   = '0;
		unique case (state_q)
			htr_pkg::S_INIT: begin
				if (idx_q == LAST_PIX) state_d = htr_pkg::S_IDLE;
			end
			htr_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (in_data.kind)
						htr_pkg::KIND_CLEAR: state_d = htr_pkg::S_CLEAR;
						htr_pkg::KIND_TRI:   state_d = htr_pkg::S_XMUL;
						htr_pkg::KIND_READ:  state_d = htr_pkg::S_READ;
						default:             state_d = htr_pkg::S_FIN;
					endcase
				end
			end
			htr_pkg::S_CLEAR: begin
				if (idx_q == LAST_PIX) state_d = htr_pkg::S_FIN;
			end
			htr_pkg::S_READ: state_d = htr_pkg::S_FIN;
			htr_pkg::S_XMUL: begin
				mac_c.issue = 1'b1;
				mac_c.clr   = !term_q;
				mac_c.sh    = 1'b0;
				if (!term_q) begin
					mac_c.a   = htr_pkg::mag32(v_q[ka][p]);
					mac_c.b   = htr_pkg::mag32(v_q[kb][q]);
					mac_c.neg = v_q[ka][p][31] ^ v_q[kb][q][31];
				end else begin
					mac_c.a   = htr_pkg::mag32(v_q[ka][q]);
					mac_c.b   = htr_pkg::mag32(v_q[kb][p]);
					mac_c.neg = !(v_q[ka][q][31] ^ v_q[kb][p][31]);
				end
				state_d = htr_pkg::S_XACC;
			end
			htr_pkg::S_XACC: state_d = term_q ? htr_pkg::S_XSTO : htr_pkg::S_XMUL;
			htr_pkg::S_XSTO: begin
				state_d = (k_q == 2'd2 && j_q == 2'd2) ? htr_pkg::S_DMUL : htr_pkg::S_XMUL;
			end
			htr_pkg::S_DMUL: begin
				mac_c.issue = 1'b1;
				mac_c.clr   = (j_q == 2'd0) && !term_q;
				mac_c.sh    = term_q;
				mac_c.a     = term_q ? crm[63:32] : crm[31:0];
				mac_c.b     = htr_pkg::mag32(v_q[0][j_q]);
				mac_c.neg   = cr_q[0][j_q][htr_pkg::CR_W-1] ^ v_q[0][j_q][31];
				state_d = htr_pkg::S_DACC;
			end
			htr_pkg::S_DACC: begin
				state_d = (j_q == 2'd2 && term_q) ? htr_pkg::S_DCHK : htr_pkg::S_DMUL;
			end
			htr_pkg::S_DCHK: begin
				state_d = acc[htr_pkg::ACC_W-1] ? htr_pkg::S_DIVGO : htr_pkg::S_FIN;
			end
			htr_pkg::S_DIVGO: begin
				div_c.start = 1'b1;
				div_c.neg   = cr_q[k_q][j_q][htr_pkg::CR_W-1];
				div_c.mag   = cr_q[k_q][j_q][htr_pkg::CR_W-1]
				              ? 64'(-cr_q[k_q][j_q]) : 64'(cr_q[k_q][j_q]);
				state_d = htr_pkg::S_DIVW;
			end
			htr_pkg::S_DIVW: begin
				if (div_done) begin
					state_d = (k_q == 2'd2 && j_q == 2'd2) ? htr_pkg::S_PINIT
					                                       : htr_pkg::S_DIVGO;
				end
			end
			htr_pkg::S_PINIT: state_d = htr_pkg::S_PIX;
			htr_pkg::S_PIX: begin
				if (idx_q == LAST_PIX) state_d = htr_pkg::S_PDRAIN;
			end
			htr_pkg::S_PDRAIN: state_d = htr_pkg::S_FIN;
			htr_pkg::S_FIN: begin
				if (!out_valid_q || !out_stall) state_d = htr_pkg::S_IDLE;
			end
			default: state_d = htr_pkg::S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htr_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: configuration, counters, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q       <= 8'd0;
			green_q     <= 8'd0;
			blue_q      <= 8'd0;
			alpha_q     <= 8'd255;
			idx_q       <= '0;
			x_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			term_q      <= 1'b0;
			vld_s1      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Configuration writes
			if (cfg_wr) begin
				unique case (paddr[3:2])
					htr_pkg::REG_RED:   red_q   <= pwdata[7:0];
					htr_pkg::REG_GREEN: green_q <= pwdata[7:0];
					htr_pkg::REG_BLUE:  blue_q  <= pwdata[7:0];
					htr_pkg::REG_ALPHA: alpha_q <= pwdata[7:0];
				endcase
			end

			vld_s1 <= (state_q == htr_pkg::S_PIX);

			// Count pixels that pass the depth test
			if (pass && count_q != htr_pkg::COUNT_MAX) begin
				count_q <= htr_pkg::CNT_W'(count_q + 1'b1);
			end

			unique case (state_q)
				htr_pkg::S_INIT, htr_pkg::S_CLEAR, htr_pkg::S_PIX: begin
					idx_q <= AW'(idx_q + 1'b1);
					if (state_q == htr_pkg::S_PIX) begin
						x_q <= (x_q == LAST_X) ? '0 : XW'(x_q + 1'b1);
					end
				end
				htr_pkg::S_IDLE: begin
					if (in_acc) begin
						idx_q   <= '0;
						k_q     <= '0;
						j_q     <= '0;
						term_q  <= 1'b0;
						count_q <= '0;
					end
				end
				htr_pkg::S_XACC, htr_pkg::S_DACC: begin
					term_q <= !term_q;
					if (state_q == htr_pkg::S_DACC && term_q) begin
						j_q <= htr_pkg::inc3(j_q);
					end
				end
				htr_pkg::S_XSTO: begin
					j_q <= htr_pkg::inc3(j_q);
					if (j_q == 2'd2) k_q <= htr_pkg::inc3(k_q);
				end
				htr_pkg::S_DIVW: begin
					if (div_done) begin
						j_q <= htr_pkg::inc3(j_q);
						if (j_q == 2'd2) k_q <= htr_pkg::inc3(k_q);
					end
				end
				htr_pkg::S_PINIT: begin
					idx_q <= '0;
					x_q   <= '0;
				end
				default: begin
				end
			endcase

			// Result handshake: drop a taken beat, load a finished one
			if (state_q == htr_pkg::S_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			htr_pkg::S_IDLE: begin
				if (in_acc) begin
					v_q[0][0] <= in_data.vert0_x;
					v_q[0][1] <= in_data.vert0_y;
					v_q[0][2] <= in_data.vert0_w;
					v_q[1][0] <= in_data.vert1_x;
					v_q[1][1] <= in_data.vert1_y;
					v_q[1][2] <= in_data.vert1_w;
					v_q[2][0] <= in_data.vert2_x;
					v_q[2][1] <= in_data.vert2_y;
					v_q[2][2] <= in_data.vert2_w;
					mask_q    <= in_data.clear_mask;
					inrange_q <= ({20'd0, in_data.pixel_index} < 32'(PIX_CNT));
					res_status_q <= htr_pkg::STATUS_DONE;
					res_color_q  <= '0;
				end
			end
			htr_pkg::S_READ: begin
				res_status_q <= htr_pkg::STATUS_READ;
				res_color_q  <= inrange_q ? rdata_c : 32'd0;
			end
			htr_pkg::S_XSTO: begin
				cr_q[k_q][j_q] <= acc[htr_pkg::CR_W-1:0];
			end
			htr_pkg::S_DCHK: begin
				if (!acc[htr_pkg::ACC_W-1]) res_status_q <= htr_pkg::STATUS_CULLED;
				dmag_q <= htr_pkg::DEN_W'(-acc);
			end
			htr_pkg::S_DIVW: begin
				if (div_done) coef_q[k_q][j_q] <= div_coef;
			end
			htr_pkg::S_PINIT: begin
				for (int i = 0; i < 3; i++) begin
					e_q[i]   <= sx(coef_q[i][0]) + sx(coef_q[i][1]) + (sx(coef_q[i][2]) <<< 1);
					row_q[i] <= sx(coef_q[i][0]) + sx(coef_q[i][1]) + (sx(coef_q[i][2]) <<< 1);
				end
			end
			htr_pkg::S_PIX: begin
				// Step the edges along the row, or down to the next row
				for (int i = 0; i < 3; i++) begin
					if (x_q == LAST_X) begin
						row_q[i] <= row_q[i] + (sx(coef_q[i][1]) <<< 1);
						e_q[i]   <= row_q[i] + (sx(coef_q[i][1]) <<< 1);
					end else begin
						e_q[i] <= e_q[i] + (sx(coef_q[i][0]) <<< 1);
					end
				end
			end
			default: begin
			end
		endcase

		// Pixel stage one
		for (int i = 0; i < 3; i++) begin
			e_s1[i] <= e_q[i];
		end
		idx_s1 <= idx_q;

		// Output beat
		if (state_q == htr_pkg::S_FIN && (!out_valid_q || !out_stall)) begin
			out_q.status         <= res_status_q;
			out_q.pixel_color    <= res_color_q;
			out_q.pixels_written <= (res_status_q == htr_pkg::STATUS_DONE) ? count_q : '0;
		end
	end

	htr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_c),
		.acc    (acc)
	);

	htr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_c),
		.den    (dmag_q),
		.done   (div_done),
		.coef   (div_coef)
	);

	htr_ram #(
		.WIDTH (32),
		.DEPTH (PIX_CNT)
	) u_color_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr_c),
		.wdata (wdata_c),
		.raddr (raddr_c),
		.rdata (rdata_c)
	);

	htr_ram #(
		.WIDTH (htr_pkg::DEPTH_W),
		.DEPTH (PIX_CNT)
	) u_depth_ram (
		.clk   (clk),
		.we    (we_d),
		.waddr (waddr_d),
		.wdata (wdata_d),
		.raddr (idx_q),
		.rdata (rdata_d)
	);

endmodule

`default_nettype wire

[rtl/htr_ram.sv]
// ============================================================================
// htr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module htr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/htr_mac.sv]
// ============================================================================
// htr_mac: shared multiply-accumulate unit
// A registered 32x32 unsigned multiply, then a signed add or subtract of the
// product, optionally shifted up 32 bits, into a wide accumulator.
// ============================================================================
`default_nettype none

module htr_mac (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire htr_pkg::mac_ctl_t             ctl,
	output logic signed [htr_pkg::ACC_W-1:0]   acc
);

	logic        vld_s1;
	logic        clr_s1;
	logic        neg_s1;
	logic        sh_s1;
	logic [63:0] prod_s1;

	logic [95:0]                       term;
	logic signed [htr_pkg::ACC_W-1:0]  ext;
	logic signed [htr_pkg::ACC_W-1:0]  base;

	// Track a product in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= {32'd0, ctl.a} * {32'd0, ctl.b};
			clr_s1  <= ctl.clr;
			neg_s1  <= ctl.neg;
			sh_s1   <= ctl.sh;
		end
	end

	// Align the product and pick the running base
	always_comb begin
		term = sh_s1 ? {prod_s1, 32'd0} : {32'd0, prod_s1};
		ext  = $signed({2'b00, term});
		base = clr_s1 ? '0 : acc;
	end

	// Accumulate stage
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc <= neg_s1 ? base - ext : base + ext;
		end
	end

endmodule

`default_nettype wire

[rtl/htr_div.sv]
// ============================================================================
// htr_div: iterative restoring divider for the inverse coefficients
// Divides a 64-bit magnitude times 2^48 by the determinant magnitude, one
// quotient bit per cycle, then saturates and gives it the sign opposite to the numerator's.
// ============================================================================
`default_nettype none

module htr_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire htr_pkg::div_ctl_t                   ctl,
	input  wire logic [htr_pkg::DEN_W-1:0]           den,
	output logic                                     done,
	output logic signed [htr_pkg::COEF_W-1:0]        coef
);

	logic                                busy_q;
	logic [6:0]                          cnt_q;
	logic [htr_pkg::NUM_W-1:0]           num_q;
	logic [htr_pkg::DEN_W-1:0]           rem_q;
	logic [htr_pkg::COEF_W-1:0]          quo_q;
	logic                                ovf_q;
	logic                                neg_q;

	logic [htr_pkg::DEN_W:0]             rs;
	logic [htr_pkg::DEN_W:0]             diff;
	logic                                ge;
	logic [htr_pkg::COEF_W-1:0]          cmag;

	// One restoring step
	always_comb begin
		rs   = {rem_q, num_q[htr_pkg::NUM_W-1]};
		diff = rs - {1'b0, den};
		ge   = (rs >= {1'b0, den});
	end

	// Saturate and sign the quotient
	always_comb begin
		cmag = (ovf_q || quo_q[htr_pkg::COEF_W-1]) ? {1'b0, htr_pkg::COEF_MAX}
		                                            : {1'b0, quo_q[htr_pkg::COEF_W-2:0]};
		coef = neg_q ? $signed(cmag) : -$signed(cmag);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= 7'(cnt_q + 7'd1);
				if (cnt_q == htr_pkg::DIV_LAST) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Datapath: load the operands, then shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= {ctl.mag, 48'd0};
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= ctl.neg;
		end else if (busy_q) begin
			num_q <= {num_q[htr_pkg::NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[htr_pkg::DEN_W-1:0] : rs[htr_pkg::DEN_W-1:0];
			quo_q <= {quo_q[htr_pkg::COEF_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[htr_pkg::COEF_W-1];
		end
	end

endmodule

`default_nettype wire
